>>> rtl/core/ihpp_pkg.sv
// Package for the IPv4 header and port parser: status codes, field structs
// and byte positions within the header. No dependencies.
package ihpp_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TRUNCATED = 2'd1,
        ST_NOT_V4    = 2'd2,
        ST_SHORT_IHL = 2'd3
    } t_status;

    // Header fields gathered from one packet
    typedef struct packed {
        logic [3:0]  header_words;
        logic [7:0]  service_type;
        logic [15:0] total_length;
        logic [15:0] identification;
        logic [15:0] flags_fragment;
        logic [7:0]  time_to_live;
        logic [7:0]  protocol_number;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [15:0] source_port;
        logic [15:0] destination_port;
    } t_hdr_fields;

    typedef struct packed {
        t_status     status;
        t_hdr_fields hdr;
    } t_result;

    // Width of the byte position counter
    localparam int unsigned POS_W = 7;

    // Protocol constants
    localparam logic [3:0] IP_VERSION_4 = 4'd4;
    localparam logic [3:0] MIN_IHL      = 4'd5;

    // Byte positions within the fixed header
    localparam logic [POS_W-1:0] POS_VER_IHL    = 7'd0;
    localparam logic [POS_W-1:0] POS_TOS        = 7'd1;
    localparam logic [POS_W-1:0] POS_LEN_HI     = 7'd2;
    localparam logic [POS_W-1:0] POS_LEN_LO     = 7'd3;
    localparam logic [POS_W-1:0] POS_ID_HI      = 7'd4;
    localparam logic [POS_W-1:0] POS_ID_LO      = 7'd5;
    localparam logic [POS_W-1:0] POS_FRAG_HI    = 7'd6;
    localparam logic [POS_W-1:0] POS_FRAG_LO    = 7'd7;
    localparam logic [POS_W-1:0] POS_TTL        = 7'd8;
    localparam logic [POS_W-1:0] POS_PROTO      = 7'd9;
    localparam logic [POS_W-1:0] POS_SRC_0      = 7'd12;
    localparam logic [POS_W-1:0] POS_SRC_1      = 7'd13;
    localparam logic [POS_W-1:0] POS_SRC_2      = 7'd14;
    localparam logic [POS_W-1:0] POS_SRC_3      = 7'd15;
    localparam logic [POS_W-1:0] POS_DST_0      = 7'd16;
    localparam logic [POS_W-1:0] POS_DST_1      = 7'd17;
    localparam logic [POS_W-1:0] POS_DST_2      = 7'd18;
    localparam logic [POS_W-1:0] POS_DST_3      = 7'd19;
    localparam logic [POS_W-1:0] POS_FIXED_LAST = 7'd19;
    localparam logic [POS_W-1:0] POS_PAYLOAD_MIN = 7'd20;
    localparam logic [POS_W-1:0] POS_LAST_MAX   = 7'd63;

endpackage

>>> rtl/core/ihpp_if.sv
// Stream interfaces of the IPv4 header and port parser: packet bytes in,
// parsed header results out. Depends on ihpp_pkg.

// Packet byte stream
interface ihpp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// Parsed header result stream
interface ihpp_result_if import ihpp_pkg::*; ;
    logic        valid;
    logic        ready;
    t_status     status;
    logic [3:0]  header_words;
    logic [7:0]  service_type;
    logic [15:0] total_length;
    logic [15:0] identification;
    logic [15:0] flags_fragment;
    logic [7:0]  time_to_live;
    logic [7:0]  protocol_number;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] source_port;
    logic [15:0] destination_port;

    modport source (
        output valid, output status, output header_words, output service_type,
        output total_length, output identification, output flags_fragment,
        output time_to_live, output protocol_number, output source_address,
        output destination_address, output source_port, output destination_port,
        input ready
    );
    modport sink (
        input valid, input status, input header_words, input service_type,
        input total_length, input identification, input flags_fragment,
        input time_to_live, input protocol_number, input source_address,
        input destination_address, input source_port, input destination_port,
        output ready
    );
endinterface

>>> rtl/core/ihpp_capture.sv
// Per-packet parse state of the IPv4 header and port parser: byte position,
// gathered header fields and the skip flag. Depends on ihpp_pkg.
module ihpp_capture import ihpp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_emit,
    output t_result    o_result
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_skip, n_skip;
    t_hdr_fields      r_hdr, n_hdr;

    logic [POS_W-1:0] payload_start;
    logic [POS_W-1:0] port_off;
    logic             in_ports;
    t_status          status;

    // Locate the port bytes after the header and its options
    assign payload_start = {1'b0, r_hdr.header_words, 2'b00};
    assign port_off      = r_pos - payload_start;
    assign in_ports      = (r_pos >= POS_PAYLOAD_MIN) && (r_pos >= payload_start)
                           && (port_off < 7'd4);

    // Capture the byte at its field and decide on a result
    always_comb begin
        n_pos  = r_pos;
        n_skip = r_skip;
        n_hdr  = (r_pos == POS_VER_IHL) ? '0 : r_hdr;
        o_emit = 1'b0;
        status = ST_OK;
        if (r_skip) begin
            n_hdr = r_hdr;
            if (i_last_byte) begin
                n_skip = 1'b0;
                n_pos  = '0;
            end
        end else if (r_pos == POS_VER_IHL && i_data_byte[7:4] != IP_VERSION_4) begin
            o_emit = 1'b1;
            status = ST_NOT_V4;
            n_pos  = '0;
            n_skip = !i_last_byte;
        end else begin
            case (r_pos)
                POS_VER_IHL: n_hdr.header_words            = i_data_byte[3:0];
                POS_TOS:     n_hdr.service_type            = i_data_byte;
                POS_LEN_HI:  n_hdr.total_length[15:8]      = i_data_byte;
                POS_LEN_LO:  n_hdr.total_length[7:0]       = i_data_byte;
                POS_ID_HI:   n_hdr.identification[15:8]    = i_data_byte;
                POS_ID_LO:   n_hdr.identification[7:0]     = i_data_byte;
                POS_FRAG_HI: n_hdr.flags_fragment[15:8]    = i_data_byte;
                POS_FRAG_LO: n_hdr.flags_fragment[7:0]     = i_data_byte;
                POS_TTL:     n_hdr.time_to_live            = i_data_byte;
                POS_PROTO:   n_hdr.protocol_number         = i_data_byte;
                POS_SRC_0:   n_hdr.source_address[31:24]   = i_data_byte;
                POS_SRC_1:   n_hdr.source_address[23:16]   = i_data_byte;
                POS_SRC_2:   n_hdr.source_address[15:8]    = i_data_byte;
                POS_SRC_3:   n_hdr.source_address[7:0]     = i_data_byte;
                POS_DST_0:   n_hdr.destination_address[31:24] = i_data_byte;
                POS_DST_1:   n_hdr.destination_address[23:16] = i_data_byte;
                POS_DST_2:   n_hdr.destination_address[15:8]  = i_data_byte;
                POS_DST_3:   n_hdr.destination_address[7:0]   = i_data_byte;
                default: begin
                    if (in_ports) begin
                        case (port_off[1:0])
                            2'd0:    n_hdr.source_port[15:8]      = i_data_byte;
                            2'd1:    n_hdr.source_port[7:0]       = i_data_byte;
                            2'd2:    n_hdr.destination_port[15:8] = i_data_byte;
                            default: n_hdr.destination_port[7:0]  = i_data_byte;
                        endcase
                    end
                end
            endcase

            // Short header length wins over an end on the last fixed byte
            if (r_pos == POS_FIXED_LAST && r_hdr.header_words < MIN_IHL) begin
                o_emit = 1'b1;
                status = ST_SHORT_IHL;
                n_pos  = '0;
                n_skip = !i_last_byte;
            end else if (r_pos >= POS_PAYLOAD_MIN && r_pos == payload_start + 7'd3) begin
                o_emit = 1'b1;
                status = ST_OK;
                n_pos  = '0;
                n_skip = !i_last_byte;
            end else if (i_last_byte) begin
                o_emit = 1'b1;
                status = ST_TRUNCATED;
                n_pos  = '0;
            end else begin
                n_pos = r_pos + 7'd1;
            end
        end
    end

    // Result carries the fields as they stand after this byte, or zeros for a version error
    always_comb begin
        o_result.status = status;
        o_result.hdr    = (status == ST_NOT_V4) ? '0 : n_hdr;
    end

    // Hold state; advance on each taken beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_skip <= 1'b0;
            r_hdr  <= '0;
        end else if (i_take) begin
            r_pos  <= n_pos;
            r_skip <= n_skip;
            r_hdr  <= n_hdr;
        end
    end

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_LAST_MAX)
        else $error("byte position beyond the largest header");
    a_skip_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip |-> r_pos == '0)
        else $error("skipping with a nonzero byte position");
    a_payload_ihl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos >= POS_PAYLOAD_MIN |-> r_hdr.header_words >= MIN_IHL)
        else $error("past the fixed header with a short header length");

endmodule

>>> rtl/core/ipv4_header_port_parser.sv
// IPv4 header and port parser, top level: byte input register, parse state
// and result register. Depends on ihpp_pkg, ihpp_if and ihpp_capture.
//
// Takes one packet byte per cycle while the result register does not stall
// the stream, and reports one result per packet: the fixed header fields and
// the two transport ports, or an error status (truncated, not version 4,
// header length below five). A byte passes through an input register and the
// parse logic into a result register. The result register stalls the byte
// stream only when it is still full and the byte waiting in the input
// register would produce another result.
module ipv4_header_port_parser import ihpp_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ihpp_byte_if.sink     i_pkt,
    ihpp_result_if.source o_hdr
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;
    logic       r_out_valid;
    t_result    r_out;

    logic       take;
    logic       emit;
    t_result    result;

    ihpp_capture u_capture (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_data_byte (r_in_byte),
        .i_last_byte (r_in_last),
        .o_emit      (emit),
        .o_result    (result)
    );

    // Consume the held byte unless it needs the result slot and the slot is full
    assign take        = r_in_valid && (!emit || !r_out_valid || o_hdr.ready);
    assign i_pkt.ready = !r_in_valid || take;

    // Hold the input beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_pkt.ready) begin
            r_in_valid <= i_pkt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pkt.ready && i_pkt.valid) begin
            r_in_byte <= i_pkt.data_byte;
            r_in_last <= i_pkt.last_byte;
        end
    end

    // Load or drain the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_hdr.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && emit) begin
            r_out <= result;
        end
    end

    // Drive the result beat
    assign o_hdr.valid               = r_out_valid;
    assign o_hdr.status              = r_out.status;
    assign o_hdr.header_words        = r_out.hdr.header_words;
    assign o_hdr.service_type        = r_out.hdr.service_type;
    assign o_hdr.total_length        = r_out.hdr.total_length;
    assign o_hdr.identification      = r_out.hdr.identification;
    assign o_hdr.flags_fragment      = r_out.hdr.flags_fragment;
    assign o_hdr.time_to_live        = r_out.hdr.time_to_live;
    assign o_hdr.protocol_number     = r_out.hdr.protocol_number;
    assign o_hdr.source_address      = r_out.hdr.source_address;
    assign o_hdr.destination_address = r_out.hdr.destination_address;
    assign o_hdr.source_port         = r_out.hdr.source_port;
    assign o_hdr.destination_port    = r_out.hdr.destination_port;

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !take |=> r_in_valid && $stable(r_in_byte) && $stable(r_in_last))
        else $error("held byte lost while the result slot was full");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_hdr.ready |-> !(take && emit))
        else $error("pending result overwritten");
    a_ok_ihl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status == ST_OK |-> r_out.hdr.header_words >= MIN_IHL)
        else $error("ok result with a short header length");
    a_short_ihl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status == ST_SHORT_IHL |-> r_out.hdr.header_words < MIN_IHL)
        else $error("short header status with a valid header length");
    a_not_v4_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.status == ST_NOT_V4 |-> r_out.hdr == '0)
        else $error("version error result carries field data");

endmodule
